// File: rtl/postfix_expression_evaluator_unit_defines.svh
// Assertion macros for the postfix evaluator RTL.
// Expects clk and rst in the scope of each use.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define PEE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PEE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pee_pkg.sv
// Shared types and constants for the postfix evaluator.
// No dependencies.
`default_nettype none

package pee_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/postfix_expression_evaluator_unit.sv
// Postfix evaluator: a digit is pushed in S_IDLE; + and - finish in S_READ, * passes on to S_MUL,
// / waits in S_DIV on the one-bit-per-cycle divider; the terminator is handled in S_IDLE.
// One word in flight; result appears the cycle after the terminator word.
// Synchronous reset empties the stack and clears the error code; RAM is not cleared.
// Depends on pee_pkg, pee_ram, pee_div and the assertion macro header.
`default_nettype none
`include "postfix_expression_evaluator_unit_defines.svh"

module postfix_expression_evaluator_unit #(
  parameter int STACK_DEPTH = 128,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               char_valid,
  output logic                    char_stall,
  input  wire logic [7:0]         char_code,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic signed [31:0]      value,
  output logic [1:0]              status
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_DIV
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [1:0]         err;
  logic signed [31:0] tos;
  pee_pkg::op_t       op;
  logic signed [63:0] prod;

  logic               accept;
  logic               is_nul;
  logic               is_digit;
  logic               is_op;
  logic               frozen;
  logic               full;
  logic [CW-1:0]      cm1;
  logic [CW-1:0]      cm2;
  logic [3:0]         dnum;
  logic [34:0]        dwide;
  logic signed [31:0] digit_val;
  logic               ram_we;
  logic [31:0]        ram_rdata;
  logic signed [31:0] lhs;
  logic signed [32:0] sum;
  logic signed [31:0] sum_sat;
  logic signed [63:0] mul_sh;
  logic signed [31:0] mul_sat;
  pee_pkg::op_t       op_code;
  pee_pkg::div_req_t  div_req;
  pee_pkg::div_rsp_t  div_rsp;

  function automatic logic [1:0] merge_err(input logic [1:0] cur, input logic [1:0] code);
    logic [1:0] res;
    res = cur;
    if (code == pee_pkg::ST_DIVZ) begin
      if (cur == pee_pkg::ST_OK) res = pee_pkg::ST_DIVZ;
    end else if (cur == pee_pkg::ST_OK || cur == pee_pkg::ST_DIVZ) begin
      res = code;
    end
    return res;
  endfunction

  assign accept   = char_valid && !char_stall;
  assign is_nul   = (char_code == pee_pkg::CH_NUL);
  assign is_digit = char_code inside {[pee_pkg::CH_ZERO:pee_pkg::CH_NINE]};
  assign is_op    = char_code inside {pee_pkg::CH_PLUS, pee_pkg::CH_MINUS,
                                      pee_pkg::CH_STAR, pee_pkg::CH_SLASH};
  assign frozen   = (err == pee_pkg::ST_UNDER) || (err == pee_pkg::ST_OVER);
  assign full     = (count >= CW'(STACK_DEPTH));
  assign cm1      = count - CW'(1);
  assign cm2      = count - CW'(2);

  assign char_stall = (state != S_IDLE) ||
                      (result_valid && result_stall && is_nul);

  always_comb begin
    case (char_code)
      pee_pkg::CH_PLUS:  op_code = pee_pkg::OP_ADD;
      pee_pkg::CH_MINUS: op_code = pee_pkg::OP_SUB;
      pee_pkg::CH_STAR:  op_code = pee_pkg::OP_MUL;
      default:           op_code = pee_pkg::OP_DIV;
    endcase
  end

  assign dnum      = 4'(char_code - pee_pkg::CH_ZERO);
  assign dwide     = 35'(dnum) << FRAC_BITS;
  assign digit_val = (dwide > 35'(pee_pkg::VAL_MAX)) ? pee_pkg::VAL_MAX
                                                      : $signed(dwide[31:0]);

  // top of stack lives in tos; entries below it live in the RAM
  assign ram_we = (state == S_IDLE) && accept && !is_nul && !frozen &&
                  is_digit && !full && (count != '0);

  pee_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cm1[AW-1:0]),
    .wdata (tos),
    .raddr (cm2[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign lhs = $signed(ram_rdata);

  always_comb begin
    if (op == pee_pkg::OP_SUB) begin
      sum = {lhs[31], lhs} - {tos[31], tos};
    end else begin
      sum = {lhs[31], lhs} + {tos[31], tos};
    end
    if (sum > 33'sh07fffffff) begin
      sum_sat = pee_pkg::VAL_MAX;
    end else if (sum < -33'sh080000000) begin
      sum_sat = pee_pkg::VAL_MIN;
    end else begin
      sum_sat = sum[31:0];
    end
  end

  assign mul_sh = prod >>> FRAC_BITS;
  assign mul_sat = (mul_sh > 64'sh000000007fffffff) ? pee_pkg::VAL_MAX :
                   (mul_sh < -64'sh0000000080000000) ? pee_pkg::VAL_MIN :
                   mul_sh[31:0];

  assign div_req.start = (state == S_READ) && (op == pee_pkg::OP_DIV) && (tos != '0);
  assign div_req.num   = lhs;
  assign div_req.den   = tos;

  pee_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      err          <= pee_pkg::ST_OK;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && !(accept && is_nul)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_nul) begin
              result_valid <= 1'b1;
              if (frozen) begin
                value  <= '0;
                status <= err;
              end else if (count == '0) begin
                value  <= '0;
                status <= pee_pkg::ST_UNDER;
              end else begin
                value  <= tos;
                status <= err;
              end
              count <= '0;
              err   <= pee_pkg::ST_OK;
            end else if (!frozen) begin
              if (is_digit) begin
                if (full) begin
                  err <= merge_err(err, pee_pkg::ST_OVER);
                end else begin
                  tos   <= digit_val;
                  count <= count + CW'(1);
                end
              end else if (is_op) begin
                if (count < CW'(2)) begin
                  err <= merge_err(err, pee_pkg::ST_UNDER);
                end else begin
                  op    <= op_code;
                  state <= S_READ;
                end
              end
            end
          end
        end
        S_READ: begin
          case (op)
            pee_pkg::OP_ADD, pee_pkg::OP_SUB: begin
              tos   <= sum_sat;
              count <= cm1;
              state <= S_IDLE;
            end
            pee_pkg::OP_MUL: begin
              prod  <= 64'(lhs) * 64'(tos);
              state <= S_MUL;
            end
            default: begin
              if (tos == '0) begin
                tos   <= lhs[31] ? pee_pkg::VAL_MIN : pee_pkg::VAL_MAX;
                err   <= merge_err(err, pee_pkg::ST_DIVZ);
                count <= cm1;
                state <= S_IDLE;
              end else begin
                state <= S_DIV;
              end
            end
          endcase
        end
        S_MUL: begin
          tos   <= mul_sat;
          count <= cm1;
          state <= S_IDLE;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            tos   <= div_rsp.quot;
            count <= cm1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PEE_ASSERT_NOW(a_count_range, 1'b1, count <= CW'(STACK_DEPTH), "stack count out of range")
  `PEE_ASSERT_NEXT(a_nul_result, accept && is_nul, result_valid, "terminator gave no result")
  `PEE_ASSERT_NEXT(a_frozen_hold, frozen && !(accept && is_nul), err == $past(err), "error lost")
  `PEE_ASSERT_NOW(a_div_state, div_rsp.done, state == S_DIV, "divider done outside divide")

endmodule

`default_nettype wire

// File: rtl/pee_ram.sv
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none

module pee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/pee_div.sv
// Iterative restoring divider: (num * 2^FRAC_BITS) / den, truncated, saturated.
// One quotient bit per cycle. Depends on pee_pkg.
`default_nettype none

module pee_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pee_pkg::div_req_t req,
  output pee_pkg::div_rsp_t      rsp
);

  localparam int NW   = 32 + FRAC_BITS;
  localparam int CNTW = $clog2(NW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic            neg;
  logic [NW-1:0]   num_sh;
  logic [NW-1:0]   quo;
  logic [31:0]     rem;
  logic [31:0]     dmag;

  logic [31:0] num_mag;
  logic [31:0] den_mag;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic        qbit;

  assign num_mag = req.num[31] ? 32'(-req.num) : 32'(req.num);
  assign den_mag = req.den[31] ? 32'(-req.den) : 32'(req.den);
  assign rem_sh  = {rem, num_sh[NW-1]};
  assign diff    = rem_sh - {1'b0, dmag};
  assign qbit    = ~diff[32];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy   <= 1'b1;
      cnt    <= CNTW'(NW);
      neg    <= req.num[31] ^ req.den[31];
      num_sh <= NW'(num_mag) << FRAC_BITS;
      quo    <= '0;
      rem    <= '0;
      dmag   <= den_mag;
    end else if (busy) begin
      if (cnt != '0) begin
        num_sh <= num_sh << 1;
        quo    <= {quo[NW-2:0], qbit};
        rem    <= qbit ? diff[31:0] : rem_sh[31:0];
        cnt    <= cnt - CNTW'(1);
      end else begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    rsp.done = busy && (cnt == '0);
    if (!neg && (quo > NW'(64'h7fffffff))) begin
      rsp.quot = pee_pkg::VAL_MAX;
    end else if (neg && (quo > NW'(64'h80000000))) begin
      rsp.quot = pee_pkg::VAL_MIN;
    end else if (neg) begin
      rsp.quot = -$signed(quo[31:0]);
    end else begin
      rsp.quot = $signed(quo[31:0]);
    end
  end

endmodule

`default_nettype wire
